// ----- sv/ehsp_pkg.sv -----
// shared types and constants of the extruder heater and stepper panel
`default_nettype none

package ehsp_pkg;

  localparam int unsigned InW      = 16;  // input tdata width
  localparam int unsigned OutW     = 48;  // output tdata width
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned ProdW    = 18;  // rpm times steps per rotation
  localparam int unsigned QuotW    = 16;
  localparam int unsigned DivCntW  = 4;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_STEPS_PER_ROT = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SAMPLE_IVL    = 2'd1;

  // button numbers inside the level vector
  localparam int unsigned BTN_TEMP_UP   = 0;
  localparam int unsigned BTN_TEMP_DOWN = 1;
  localparam int unsigned BTN_STEP_SIZE = 2;
  localparam int unsigned BTN_SPEED_UP  = 3;
  localparam int unsigned BTN_SPEED_DN  = 4;
  localparam int unsigned BTN_RUN       = 5;

  localparam logic [9:0]       TARGET_MAX    = 10'd999;
  localparam logic [9:0]       RPM_MAX       = 10'd999;
  localparam logic [9:0]       RPM_STEP      = 10'd10;
  localparam logic [6:0]       STEP_ONE      = 7'd1;
  localparam logic [6:0]       STEP_TEN      = 7'd10;
  localparam logic [6:0]       STEP_HUNDRED  = 7'd100;
  localparam logic [QuotW-1:0] DELAY_NUM     = 16'd60000;
  localparam logic [7:0]       SPR_RESET     = 8'd5;
  localparam logic [15:0]      SAMPLE_RESET  = 16'd1000;
  localparam logic [DivCntW-1:0] DIV_LAST    = 4'd15;

  // controller to datapath
  typedef struct packed {
    logic latch_in;
    logic update;
    logic mul;
    logic div_step;
    logic div_last;
    logic clear_delay;
    logic step;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic reload;
    logic prod_zero;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ----- sv/ehsp_ctrl.sv -----
// sequencing state machine of the panel
`default_nettype none

module ehsp_ctrl (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              in_valid_i,
  output logic             in_ready_o,
  input  ehsp_pkg::sts_t   sts_i,
  output ehsp_pkg::cmd_t   cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPD,
    ST_MUL,
    ST_DIV,
    ST_STEP,
    ST_OUT
  } state_e;

  state_e                         state_q, state_d;
  logic [ehsp_pkg::DivCntW-1:0]   cnt_q, cnt_d;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o     = 1'b1;
        cmd_o.latch_in = in_valid_i;
        if (in_valid_i) state_d = ST_UPD;
      end
      ST_UPD: begin
        cmd_o.update = 1'b1;
        state_d      = sts_i.reload ? ST_MUL : ST_STEP;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        cnt_d     = '0;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        if (sts_i.prod_zero) begin
          cmd_o.clear_delay = 1'b1;
          state_d           = ST_STEP;
        end else begin
          cmd_o.div_step = 1'b1;
          cnt_d          = cnt_q + 1'b1;
          if (cnt_q == ehsp_pkg::DIV_LAST) begin
            cmd_o.div_last = 1'b1;
            state_d        = ST_STEP;
          end
        end
      end
      ST_STEP: begin
        cmd_o.step = 1'b1;
        state_d    = ST_OUT;
      end
      ST_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ----- sv/ehsp_dp.sv -----
// panel datapath: settings, buttons, sampling, step delay divider, stepping, result register
`default_nettype none

module ehsp_dp (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  ehsp_pkg::cmd_t                   cmd_i,
  output ehsp_pkg::sts_t                   sts_o,
  input  wire [ehsp_pkg::InW-1:0]          in_data_i,
  input  wire                              cfg_we_i,
  input  wire [ehsp_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  wire [ehsp_pkg::CfgDataW-1:0]     cfg_data_i,
  input  wire                              out_ready_i,
  output logic                             out_valid_o,
  output logic [ehsp_pkg::OutW-1:0]        out_data_o
);

  // configuration
  logic [7:0]  spr_q;
  logic [15:0] ivl_q;

  // latched tick
  logic [5:0]  lvl_q;
  logic [9:0]  adc_q;

  // panel state
  logic [5:0]  armed_q;
  logic [6:0]  ss_q, ss_d;
  logic [9:0]  tgt_q, tgt_d;
  logic [9:0]  rpm_q, rpm_d;
  logic        run_q;
  logic [1:0]  phase_q;
  logic [3:0]  coil_q;
  logic [15:0] delay_q;
  logic [16:0] step_el_q;
  logic [15:0] smp_el_q;
  logic [9:0]  cur_q;

  // divider
  logic [ehsp_pkg::ProdW-1:0] prod_q;
  logic [ehsp_pkg::ProdW-1:0] rem_q, rem_d;
  logic [ehsp_pkg::QuotW-1:0] quo_q, quo_d;
  logic [ehsp_pkg::ProdW:0]   trial;

  logic [5:0]  press;
  logic [10:0] tgt_sum, rpm_sum;
  logic [9:0]  tgt_up, rpm_up;
  logic [16:0] smp_e;
  logic [17:0] step_e;
  logic        do_step;
  logic        out_valid_q;

  assign press = lvl_q & ~armed_q;

  // button arithmetic, in the order step size, target up/down, rpm up/down
  always_comb begin
    ss_d = ss_q;
    if (press[ehsp_pkg::BTN_STEP_SIZE]) begin
      priority if (ss_q == ehsp_pkg::STEP_ONE) ss_d = ehsp_pkg::STEP_TEN;
      else if (ss_q == ehsp_pkg::STEP_TEN)     ss_d = ehsp_pkg::STEP_HUNDRED;
      else                                     ss_d = ehsp_pkg::STEP_ONE;
    end

    tgt_sum = {1'b0, tgt_q} + {4'b0, ss_d};
    tgt_up  = tgt_q;
    if (press[ehsp_pkg::BTN_TEMP_UP]) begin
      tgt_up = (tgt_sum > {1'b0, ehsp_pkg::TARGET_MAX}) ? ehsp_pkg::TARGET_MAX
                                                         : tgt_sum[9:0];
    end
    tgt_d = tgt_up;
    if (press[ehsp_pkg::BTN_TEMP_DOWN]) begin
      tgt_d = (tgt_up > {3'b0, ss_d}) ? tgt_up - {3'b0, ss_d} : '0;
    end

    rpm_sum = {1'b0, rpm_q} + {1'b0, ehsp_pkg::RPM_STEP};
    rpm_up  = rpm_q;
    if (press[ehsp_pkg::BTN_SPEED_UP]) begin
      rpm_up = (rpm_sum > {1'b0, ehsp_pkg::RPM_MAX}) ? ehsp_pkg::RPM_MAX : rpm_sum[9:0];
    end
    rpm_d = rpm_up;
    if (press[ehsp_pkg::BTN_SPEED_DN]) begin
      rpm_d = (rpm_up > ehsp_pkg::RPM_STEP) ? rpm_up - ehsp_pkg::RPM_STEP : '0;
    end
  end

  assign smp_e  = {1'b0, smp_el_q} + 17'd1;
  assign step_e = {1'b0, step_el_q} + 18'd1;
  assign do_step = run_q && (delay_q != '0) && (step_e > {2'b0, delay_q});

  // one restoring division step per cycle
  always_comb begin
    trial = {rem_q, quo_q[ehsp_pkg::QuotW-1]};
    if (trial >= {1'b0, prod_q}) begin
      rem_d = ehsp_pkg::ProdW'(trial - {1'b0, prod_q});
      quo_d = {quo_q[ehsp_pkg::QuotW-2:0], 1'b1};
    end else begin
      rem_d = trial[ehsp_pkg::ProdW-1:0];
      quo_d = {quo_q[ehsp_pkg::QuotW-2:0], 1'b0};
    end
  end

  assign sts_o.reload    = press[ehsp_pkg::BTN_SPEED_UP] | press[ehsp_pkg::BTN_SPEED_DN];
  assign sts_o.prod_zero = (prod_q == '0);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spr_q     <= ehsp_pkg::SPR_RESET;
      ivl_q     <= ehsp_pkg::SAMPLE_RESET;
      armed_q   <= '0;
      ss_q      <= ehsp_pkg::STEP_ONE;
      tgt_q     <= '0;
      rpm_q     <= '0;
      run_q     <= 1'b0;
      phase_q   <= '0;
      coil_q    <= '0;
      delay_q   <= '0;
      step_el_q <= '0;
      smp_el_q  <= '0;
      cur_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          ehsp_pkg::CFG_STEPS_PER_ROT: spr_q <= cfg_data_i[7:0];
          ehsp_pkg::CFG_SAMPLE_IVL:    ivl_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.update) begin
        if (smp_e > {1'b0, ivl_q}) begin
          cur_q    <= adc_q;
          smp_el_q <= '0;
        end else begin
          smp_el_q <= smp_e[16] ? 16'hFFFF : smp_e[15:0];
        end
        armed_q <= lvl_q;
        ss_q    <= ss_d;
        tgt_q   <= tgt_d;
        rpm_q   <= rpm_d;
        run_q   <= run_q ^ press[ehsp_pkg::BTN_RUN];
      end
      if (cmd_i.clear_delay) delay_q <= '0;
      if (cmd_i.div_last)    delay_q <= quo_d;
      if (cmd_i.step) begin
        if (do_step) begin
          coil_q    <= 4'(4'b0001 << phase_q);
          phase_q   <= phase_q + 1'b1;
          step_el_q <= '0;
        end else begin
          step_el_q <= step_e[17] ? 17'h1FFFF : step_e[16:0];
        end
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      lvl_q <= in_data_i[5:0];
      adc_q <= in_data_i[15:6];
    end
    if (cmd_i.mul) begin
      prod_q <= ehsp_pkg::ProdW'(rpm_q) * ehsp_pkg::ProdW'(spr_q);
      rem_q  <= '0;
      quo_q  <= ehsp_pkg::DELAY_NUM;
    end
    if (cmd_i.div_step) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
    if (cmd_i.load_out) begin
      out_data_o <= {5'b0, run_q, rpm_q, ss_q, tgt_q, cur_q, coil_q, cur_q < tgt_q};
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ----- sv/extruder_heater_stepper_panel_top.sv -----
// top level of the extruder heater and stepper control panel
`default_nettype none

// One input transaction is one millisecond tick carrying six button levels and
// a temperature reading; each tick gives exactly one result transaction with
// the panel state after that tick. When a speed button was pressed, a tick
// runs through accept, update, multiply, the bit-serial divider that forms
// 60000/(rpm*steps_per_rotation), stepping and result; otherwise it runs
// through accept, update, stepping and result. When the product is zero the
// divider does no division step and clears the step delay instead. The divider
// makes the speed button path the longer one. A finished result sits in an
// output register, so the next tick is taken while it waits; the result cycle
// of that next tick is held until the waiting result has gone. The
// configuration channel is always ready; steps_per_rotation only takes
// effect at the next speed button press.
module extruder_heater_stepper_panel_top (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  // tick stream
  input  wire                               s_axis_tvalid,
  output logic                              s_axis_tready,
  // temp_up_level[0], temp_down_level[1], step_size_level[2], speed_up_level[3],
  // speed_down_level[4], run_toggle_level[5], adc_sample[15:6]
  input  wire  [ehsp_pkg::InW-1:0]          s_axis_tdata,
  // result stream
  output logic                              m_axis_tvalid,
  input  wire                               m_axis_tready,
  // heater_on[0], coil_pattern[4:1], current_level[14:5], target_level[24:15],
  // step_size[31:25], motor_rpm[41:32], motor_running[42], zero fill above
  output logic [ehsp_pkg::OutW-1:0]         m_axis_tdata,
  // configuration writes
  input  wire                               cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire  [ehsp_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  wire  [ehsp_pkg::CfgDataW-1:0]     cfg_data_i
);

  ehsp_pkg::cmd_t cmd;
  ehsp_pkg::sts_t sts;

  // registers are simple flops, a write transaction is never held off
  assign cfg_ready_o = 1'b1;

  ehsp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ehsp_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (s_axis_tdata),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata)
  );

`ifndef ASSERT_OFF
  // coil drive is never more than one coil
  a_coil_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> $onehot0(m_axis_tdata[4:1]))
    else $error("coil pattern not one-hot");

  // setpoints stay inside their saturation limits
  a_limits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[24:15] <= ehsp_pkg::TARGET_MAX) &&
                      (m_axis_tdata[41:32] <= ehsp_pkg::RPM_MAX))
    else $error("target or rpm above limit");

  // step size cycles through its three values only
  a_step_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[31:25] == ehsp_pkg::STEP_ONE) ||
                      (m_axis_tdata[31:25] == ehsp_pkg::STEP_TEN) ||
                      (m_axis_tdata[31:25] == ehsp_pkg::STEP_HUNDRED))
    else $error("illegal step size");

  // a tick is not taken in the cycle right after another was taken
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("tick taken while busy");
`endif

endmodule

`default_nettype wire

// ----- tb/ehsp_result_checker.sv -----
// checker that predicts each panel result from the accepted ticks and compares it field by field
module ehsp_result_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          tick_valid_i,
  input  logic                          tick_ready_i,
  input  logic [ehsp_pkg::InW-1:0]      tick_data_i,
  input  logic                          panel_valid_i,
  input  logic                          panel_ready_i,
  input  logic [ehsp_pkg::OutW-1:0]     panel_data_i,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [ehsp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [ehsp_pkg::CfgDataW-1:0] cfg_data_i,
  output int                            pending_o,
  output int                            fails_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned StepAgeMax = 131071;

  // result layout, lowest field in the lowest bits
  typedef struct packed {
    logic [4:0] fill;
    logic       running;
    logic [9:0] rpm;
    logic [6:0] step_size;
    logic [9:0] target;
    logic [9:0] current;
    logic [3:0] coil;
    logic       heater;
  } panel_state_t;

  logic [7:0]   steps_per_rot;
  logic [15:0]  sample_ivl;
  logic [5:0]   armed;
  logic [6:0]   step_size;
  logic [9:0]   target;
  logic [9:0]   rpm;
  logic         running;
  logic [1:0]   phase;
  logic [3:0]   coil;
  logic [15:0]  step_delay;
  logic [16:0]  step_age;
  logic [15:0]  sample_age;
  logic [9:0]   current;
  panel_state_t expected_states[$];
  int           fails = 0;

  initial begin
    pending_o = 0;
    fails_o   = 0;
  end

  function automatic void clear_panel();
    steps_per_rot = ehsp_pkg::SPR_RESET;
    sample_ivl    = ehsp_pkg::SAMPLE_RESET;
    armed         = '0;
    step_size     = ehsp_pkg::STEP_ONE;
    target        = '0;
    rpm           = '0;
    running       = 1'b0;
    phase         = '0;
    coil          = '0;
    step_delay    = '0;
    step_age      = '0;
    sample_age    = '0;
    current       = '0;
    expected_states.delete();
  endfunction

  // rising edge of a button, re-armed on release
  function automatic logic press_edge(int unsigned btn, logic [5:0] levels);
    if (!levels[btn]) begin
      armed[btn] = 1'b0;
      return 1'b0;
    end
    if (armed[btn]) return 1'b0;
    armed[btn] = 1'b1;
    return 1'b1;
  endfunction

  function automatic void reload_step_delay();
    int unsigned prod;
    prod = 32'(rpm) * 32'(steps_per_rot);
    step_delay = (prod == 0) ? '0 : 16'(32'(ehsp_pkg::DELAY_NUM) / prod);
  endfunction

  function automatic panel_state_t next_panel_state(logic [5:0] levels, logic [9:0] adc);
    panel_state_t r;
    int unsigned  age;
    int unsigned  sum;
    age = 32'(sample_age) + 1;
    if (age > sample_ivl) begin
      current    = adc;
      sample_age = '0;
    end else begin
      sample_age = 16'(age);  // bounded by the interval, so no ceiling needed
    end

    if (press_edge(ehsp_pkg::BTN_STEP_SIZE, levels)) begin
      if (step_size == ehsp_pkg::STEP_ONE) step_size = ehsp_pkg::STEP_TEN;
      else if (step_size == ehsp_pkg::STEP_TEN) step_size = ehsp_pkg::STEP_HUNDRED;
      else step_size = ehsp_pkg::STEP_ONE;
    end
    if (press_edge(ehsp_pkg::BTN_TEMP_UP, levels)) begin
      sum    = 32'(target) + 32'(step_size);
      target = (sum > ehsp_pkg::TARGET_MAX) ? ehsp_pkg::TARGET_MAX : 10'(sum);
    end
    if (press_edge(ehsp_pkg::BTN_TEMP_DOWN, levels))
      target = (target > step_size) ? target - 10'(step_size) : '0;
    if (press_edge(ehsp_pkg::BTN_SPEED_UP, levels)) begin
      sum = 32'(rpm) + 32'(ehsp_pkg::RPM_STEP);
      rpm = (sum > ehsp_pkg::RPM_MAX) ? ehsp_pkg::RPM_MAX : 10'(sum);
      reload_step_delay();
    end
    if (press_edge(ehsp_pkg::BTN_SPEED_DN, levels)) begin
      rpm = (rpm > ehsp_pkg::RPM_STEP) ? rpm - ehsp_pkg::RPM_STEP : '0;
      reload_step_delay();
    end
    if (press_edge(ehsp_pkg::BTN_RUN, levels)) running = ~running;

    age = 32'(step_age) + 1;
    if (running && step_delay != '0 && age > step_delay) begin
      coil     = 4'b0001 << phase;
      phase    = phase + 2'd1;
      step_age = '0;
    end else begin
      step_age = (age > StepAgeMax) ? 17'(StepAgeMax) : 17'(age);
    end

    r           = '0;
    r.heater    = (current < target);
    r.coil      = coil;
    r.current   = current;
    r.target    = target;
    r.step_size = step_size;
    r.rpm       = rpm;
    r.running   = running;
    return r;
  endfunction

  task automatic check_field(string name, logic [15:0] want_v, logic [15:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    panel_state_t got;
    panel_state_t want;
    if (!rst_ni) begin
      clear_panel();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          ehsp_pkg::CFG_STEPS_PER_ROT: steps_per_rot = cfg_data_i[7:0];
          ehsp_pkg::CFG_SAMPLE_IVL:    sample_ivl    = cfg_data_i;
          default: ;  // no register behind other indexes
        endcase
      end
      if (panel_valid_i && panel_ready_i) begin
        got = panel_data_i;
        if (expected_states.size() == 0) begin
          $error("panel result %h with no tick waiting", panel_data_i);
          fails++;
        end else begin
          want = expected_states.pop_front();
          check_field("heater_on", 16'(want.heater), 16'(got.heater));
          check_field("coil_pattern", 16'(want.coil), 16'(got.coil));
          check_field("current_level", 16'(want.current), 16'(got.current));
          check_field("target_level", 16'(want.target), 16'(got.target));
          check_field("step_size", 16'(want.step_size), 16'(got.step_size));
          check_field("motor_rpm", 16'(want.rpm), 16'(got.rpm));
          check_field("motor_running", 16'(want.running), 16'(got.running));
        end
      end
      if (tick_valid_i && tick_ready_i)
        expected_states.push_back(next_panel_state(tick_data_i[5:0], tick_data_i[15:6]));
    end
    pending_o <= expected_states.size();
    fails_o   <= fails;
  end

endmodule

// ----- tb/tb_extruder_heater_stepper_panel_top.sv -----
// testbench top of the extruder heater and stepper panel: stimulus, idling and verdict
module tb_extruder_heater_stepper_panel_top;
  timeunit 1ns;
  timeprecision 1ps;

  // button masks inside the level vector of a tick
  localparam logic [5:0] UpBtn    = 6'b1 << ehsp_pkg::BTN_TEMP_UP;
  localparam logic [5:0] DownBtn  = 6'b1 << ehsp_pkg::BTN_TEMP_DOWN;
  localparam logic [5:0] StepBtn  = 6'b1 << ehsp_pkg::BTN_STEP_SIZE;
  localparam logic [5:0] SpdUpBtn = 6'b1 << ehsp_pkg::BTN_SPEED_UP;
  localparam logic [5:0] SpdDnBtn = 6'b1 << ehsp_pkg::BTN_SPEED_DN;
  localparam logic [5:0] RunBtn   = 6'b1 << ehsp_pkg::BTN_RUN;
  localparam logic [5:0] AllBtns  = UpBtn | DownBtn | StepBtn | SpdUpBtn | SpdDnBtn | RunBtn;
  localparam logic [9:0] AdcMax   = 10'd1023;

  // indexes with no register behind them, written to see them ignored
  localparam logic [ehsp_pkg::CfgIdxW-1:0] CfgSpare2 = 2'd2;
  localparam logic [ehsp_pkg::CfgIdxW-1:0] CfgSpare3 = 2'd3;

  localparam int unsigned RxHoldCycles = 180;         // long receiver hold-off
  localparam int unsigned TailCycles   = 40;          // longer than the longest tick
  localparam int unsigned TimeoutNs    = 10_000_000;  // far beyond the slowest passing run

  logic                          clk_i         = 1'b0;
  logic                          rst_ni        = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [ehsp_pkg::InW-1:0]      s_axis_tdata  = '0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [ehsp_pkg::OutW-1:0]     m_axis_tdata;
  logic                          cfg_valid_i   = 1'b0;
  logic                          cfg_ready_o;
  logic [ehsp_pkg::CfgIdxW-1:0]  cfg_index_i   = '0;
  logic [ehsp_pkg::CfgDataW-1:0] cfg_data_i    = '0;

  int          pending;
  int          fails;
  int unsigned tx_idle_pct  = 0;    // chance of a gap before a tick
  int unsigned rx_stall_pct = 0;    // chance per cycle that results are held off
  logic        rx_hold      = 1'b0;
  logic [5:0]  held_buttons = '0;   // button levels carried from tick to tick
  event        rx_hold_kick;

  always #6 clk_i = ~clk_i;

  extruder_heater_stepper_panel_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // watches all three channels, predicts every tick and compares the results
  ehsp_result_checker results_chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .tick_valid_i  (s_axis_tvalid),
    .tick_ready_i  (s_axis_tready),
    .tick_data_i   (s_axis_tdata),
    .panel_valid_i (m_axis_tvalid),
    .panel_ready_i (m_axis_tready),
    .panel_data_i  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .pending_o     (pending),
    .fails_o       (fails)
  );

  // result side: random stalls, forced low during a hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (rx_hold) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // long hold-off, counted here so the sender keeps offering ticks meanwhile
  initial begin
    forever begin
      @(rx_hold_kick);
      @(posedge clk_i);
      rx_hold <= 1'b1;
      repeat (RxHoldCycles) @(posedge clk_i);
      rx_hold <= 1'b0;
    end
  end

  // one tick transaction, with an optional gap in front; ready is read mid-cycle
  task automatic send_tick(input logic [5:0] levels, input logic [9:0] adc);
    logic took;
    if ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(24, 1)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {adc, levels};
    do begin
      @(negedge clk_i);
      took = s_axis_tready;
      @(posedge clk_i);
    end while (!took);
  endtask

  // stop offering ticks until every predicted result has come out
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [ehsp_pkg::CfgIdxW-1:0] idx,
                           input logic [ehsp_pkg::CfgDataW-1:0] value);
    logic took;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do begin
      @(negedge clk_i);
      took = cfg_ready_o;
      @(posedge clk_i);
    end while (!took);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // random ticks: buttons are held for a while and released, so most presses are
  // clean edges; now and then the whole level vector is scrambled
  task automatic run_phase(input int unsigned count, input int unsigned up_pct,
                           input int unsigned dn_pct, input int unsigned spd_up_pct,
                           input int unsigned spd_dn_pct);
    int unsigned press_pct [6];
    logic [9:0]  adc;
    press_pct[ehsp_pkg::BTN_TEMP_UP]   = up_pct;
    press_pct[ehsp_pkg::BTN_TEMP_DOWN] = dn_pct;
    press_pct[ehsp_pkg::BTN_STEP_SIZE] = 6;
    press_pct[ehsp_pkg::BTN_SPEED_UP]  = spd_up_pct;
    press_pct[ehsp_pkg::BTN_SPEED_DN]  = spd_dn_pct;
    press_pct[ehsp_pkg::BTN_RUN]       = 3;
    repeat (count) begin
      if ($urandom_range(9) == 0) begin
        held_buttons = 6'($urandom_range(63));
      end else begin
        for (int b = 0; b < 6; b++) begin
          if (held_buttons[b]) begin
            if ($urandom_range(1) == 1) held_buttons[b] = 1'b0;
          end else if ($urandom_range(99) < press_pct[b]) begin
            held_buttons[b] = 1'b1;
          end
        end
      end
      case ($urandom_range(7))
        0:       adc = '0;
        1:       adc = AdcMax;
        default: adc = 10'($urandom_range(1023));
      endcase
      send_tick(held_buttons, adc);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: long sample interval, nothing latched yet
    send_tick('0, '0);
    send_tick('0, AdcMax);
    send_tick(DownBtn | SpdDnBtn, 10'h2AA);   // both floors at zero, zero rpm reload
    drain_results();

    // upper byte of the data is dropped for steps per rotation
    write_reg(ehsp_pkg::CFG_STEPS_PER_ROT, 16'hFFC8);
    write_reg(ehsp_pkg::CFG_SAMPLE_IVL, 16'd0);   // latch on every tick

    send_tick(AllBtns, AdcMax);                    // every button in one tick
    send_tick('0, 10'h155);                        // all released, re-armed
    send_tick(StepBtn, 10'h2AA);                   // step size to 100
    send_tick(StepBtn | UpBtn, '0);                // held step button does nothing
    send_tick('0, '0);
    send_tick(StepBtn | SpdUpBtn, 10'd50);         // step size wraps to 1, rpm 10
    send_tick(UpBtn, 10'd100);
    send_tick('0, 10'd101);                        // current equals target, heater off
    send_tick(RunBtn, AdcMax);                     // stepper off again
    send_tick('0, '0);
    send_tick(RunBtn | SpdUpBtn, '0);              // on, with a shorter step delay
    send_tick(DownBtn, '0);
    send_tick('0, '0);
    held_buttons = '0;

    // steps per rotation 200, fast stepping at low rpm, no idling
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    run_phase(230, 20, 8, 20, 10);
    drain_results();

    // one step per rotation, sender idles
    write_reg(ehsp_pkg::CFG_STEPS_PER_ROT, 16'd1);
    write_reg(ehsp_pkg::CFG_SAMPLE_IVL, 16'd1);
    tx_idle_pct  = 57;
    rx_stall_pct = 0;
    run_phase(230, 8, 20, 25, 5);
    drain_results();

    // widest steps per rotation, receiver stalls
    write_reg(ehsp_pkg::CFG_STEPS_PER_ROT, 16'd255);
    write_reg(ehsp_pkg::CFG_SAMPLE_IVL, 16'd3);
    tx_idle_pct  = 0;
    rx_stall_pct = 57;
    run_phase(230, 20, 5, 5, 25);
    drain_results();

    // zero steps per rotation: no steps after a speed press, longest interval never latches
    write_reg(ehsp_pkg::CFG_STEPS_PER_ROT, 16'd0);
    write_reg(ehsp_pkg::CFG_SAMPLE_IVL, 16'hFFFF);
    write_reg(CfgSpare2, 16'hFFFF);
    write_reg(CfgSpare3, 16'h5A5A);
    tx_idle_pct  = 32;
    rx_stall_pct = 32;
    run_phase(230, 15, 15, 15, 15);
    drain_results();

    // back pressure: results held off for a long stretch while ticks keep coming
    write_reg(ehsp_pkg::CFG_STEPS_PER_ROT, 16'd120);
    write_reg(ehsp_pkg::CFG_SAMPLE_IVL, 16'd2);
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    -> rx_hold_kick;
    run_phase(60, 15, 15, 15, 15);
    drain_results();                                // sender pauses until all are out
    tx_idle_pct  = 32;
    rx_stall_pct = 57;
    run_phase(100, 15, 15, 15, 15);
    tx_idle_pct  = 57;
    rx_stall_pct = 32;
    run_phase(70, 15, 15, 15, 15);
    drain_results();

    // anything the block still sends now would be an unexpected result
    repeat (TailCycles) @(posedge clk_i);
    if (fails == 0 && pending == 0) begin
      $display("** extruder_heater_stepper_panel_top: PASSED **");
    end else begin
      $display("** extruder_heater_stepper_panel_top: FAILED **");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(TimeoutNs);
    $display("** extruder_heater_stepper_panel_top: FAILED **");
    $finish;
  end

endmodule

// ----- files.f -----
sv/ehsp_pkg.sv
sv/ehsp_ctrl.sv
sv/ehsp_dp.sv
sv/extruder_heater_stepper_panel_top.sv
tb/ehsp_result_checker.sv
tb/tb_extruder_heater_stepper_panel_top.sv
